/* rtl/core/mhd_pkg.sv */
`default_nettype none

package mhd_pkg;

   // Default sizes for the top-level parameters.
   localparam int HISTORY_SIZE_DEF    = 65536;
   localparam int BIT_BUFFER_BITS_DEF = 64;

   // Width of a copy length and of a decoded offset.
   localparam int LEN_W = 16;
   localparam int OFF_W = 17;

   // Depth of the result queue behind the history read stage.
   localparam int OUTQ_DEPTH = 3;

   // Operation codes of an input word.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Register indexes of the control port.
   localparam logic REG_HISTORY_MODE = 1'b0;

   // Result status codes.
   localparam logic [3:0] ST_ACCEPTED   = 4'd0;
   localparam logic [3:0] ST_FULL       = 4'd1;
   localparam logic [3:0] ST_PASS       = 4'd2;
   localparam logic [3:0] ST_DECODED    = 4'd3;
   localparam logic [3:0] ST_WAIT       = 4'd4;
   localparam logic [3:0] ST_DONE       = 4'd5;
   localparam logic [3:0] ST_BAD_OFFSET = 4'd6;
   localparam logic [3:0] ST_BAD_LENGTH = 4'd7;
   localparam logic [3:0] ST_HIST_FULL  = 4'd8;
   localparam logic [3:0] ST_OVERFLOW   = 4'd9;

   // Offset bases of the match codes.
   localparam logic [OFF_W-1:0] OFF_BASE_1 = 17'd64;
   localparam logic [OFF_W-1:0] OFF_BASE_2 = 17'd320;
   localparam logic [OFF_W-1:0] OFF_BASE_3 = 17'd2368;

   // Source masks for the two history modes.
   localparam logic [15:0] SRC_MASK_8K  = 16'h1FFF;
   localparam logic [15:0] SRC_MASK_64K = 16'hFFFF;

   // One input word.
   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
      logic       first_of_packet;
      logic       last_of_packet;
      logic       flag_compressed;
      logic       flag_at_front;
      logic       flag_flushed;
   } mhd_item_type;

   // What the decoder hands to the history stage for one word.
   typedef struct packed {
      logic [3:0] status;
      logic       eop;
      logic [7:0] lit;
      logic       use_mem;
      logic       rd_valid;
      logic       wen;
   } mhd_desc_type;

   // One result word.
   typedef struct packed {
      logic [7:0] out_byte;
      logic [3:0] status;
      logic       end_of_packet;
   } mhd_result_type;

endpackage

`default_nettype wire

/* rtl/core/mhd_if.sv */
`default_nettype none

// Input channel.
interface mhd_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;
   logic       first_of_packet;
   logic       last_of_packet;
   logic       flag_compressed;
   logic       flag_at_front;
   logic       flag_flushed;

   modport source (
      output valid, operation, data_byte, first_of_packet, last_of_packet,
             flag_compressed, flag_at_front, flag_flushed,
      input  ready
   );
   modport sink (
      input  valid, operation, data_byte, first_of_packet, last_of_packet,
             flag_compressed, flag_at_front, flag_flushed,
      output ready
   );
endinterface

// Result channel.
interface mhd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [3:0] status;
   logic       end_of_packet;

   modport source (
      output valid, out_byte, status, end_of_packet,
      input  ready
   );
   modport sink (
      input  valid, out_byte, status, end_of_packet,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/core/mhd_decoder.sv */
`default_nettype none

module mhd_decoder import mhd_pkg::*; #(
   parameter int HISTORY_SIZE    = HISTORY_SIZE_DEF,
   parameter int BIT_BUFFER_BITS = BIT_BUFFER_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            history_mode,
   input  wire logic                            accept,
   input  wire mhd_item_type                    item,
   output mhd_desc_type                         desc,
   output logic [$clog2(HISTORY_SIZE)-1:0]      rd_addr,
   output logic [$clog2(HISTORY_SIZE)-1:0]      wr_addr
);

   localparam int AW = $clog2(HISTORY_SIZE);
   localparam int PW = $clog2(HISTORY_SIZE + 1);
   localparam int CW = $clog2(BIT_BUFFER_BITS + 1);
   localparam int BB = BIT_BUFFER_BITS;

   // Decoder state. The bit buffer is kept left aligned with zeros below.
   logic [PW-1:0]    wp_ff, wp_in;
   logic [PW-1:0]    start_ff, start_in;
   logic [PW-1:0]    hwm_ff, hwm_in;
   logic [BB-1:0]    buf_ff, buf_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [AW-1:0]    src_ff, src_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic             act_ff, act_in;
   logic             comp_ff, comp_in;
   logic             end_ff, end_in;
   logic             hold_ff, hold_in;

   // Token decode from the head of the bit buffer.
   logic [31:0]      win;
   logic [BB-1:0]    shl_need;
   logic [31:0]      win2;
   logic             is_lit;
   logic [7:0]       lit_byte;
   logic [4:0]       lit_need;
   logic [OFF_W-1:0] off;
   logic [4:0]       need;
   logic [4:0]       k;
   logic             run;
   logic [5:0]       lneed;
   logic [31:0]      len_wide;
   logic [31:0]      len_mask;
   logic [LEN_W-1:0] len;
   logic [6:0]       total;
   logic [6:0]       cnt_ext;
   logic [4:0]       k_limit;
   logic [16:0]      src_diff;
   logic [15:0]      src_masked;
   logic [16:0]      src_mod;
   logic [AW-1:0]    src_start;
   logic [16:0]      src_next;
   logic [AW-1:0]    src_follow;
   logic [16:0]      src_start_next;
   logic [AW-1:0]    src_start_follow;
   logic [17:0]      end_pos;

   always_comb begin
      win      = buf_ff[BB-1 -: 32];
      is_lit   = !win[31] || (win[31:30] == 2'b10);
      lit_byte = win[31] ? {1'b1, win[29:23]} : {1'b0, win[30:24]};
      lit_need = win[31] ? 5'd9 : 5'd8;
      if (history_mode) begin
         if (win[31:27] == 5'b11111) begin
            off  = OFF_W'(win[26:21]);
            need = 5'd11;
         end else if (win[31:27] == 5'b11110) begin
            off  = OFF_W'(win[26:19]) + OFF_BASE_1;
            need = 5'd13;
         end else if (win[31:28] == 4'b1110) begin
            off  = OFF_W'(win[27:17]) + OFF_BASE_2;
            need = 5'd15;
         end else begin
            off  = OFF_W'(win[28:13]) + OFF_BASE_3;
            need = 5'd19;
         end
      end else begin
         if (win[31:28] == 4'b1111) begin
            off  = OFF_W'(win[27:22]);
            need = 5'd10;
         end else if (win[31:28] == 4'b1110) begin
            off  = OFF_W'(win[27:20]) + OFF_BASE_1;
            need = 5'd12;
         end else begin
            off  = OFF_W'(win[28:16]) + OFF_BASE_2;
            need = 5'd16;
         end
      end
      shl_need = buf_ff << need;
      win2     = shl_need[BB-1 -: 32];

      // Count the leading ones of the length prefix, up to sixteen.
      k   = 5'd0;
      run = 1'b1;
      for (int i = 0; i < 16; i++) begin
         if (run && win2[31-i]) begin
            k = 5'(i + 1);
         end else begin
            run = 1'b0;
         end
      end
      k_limit  = history_mode ? 5'd15 : 5'd12;
      lneed    = (k == 5'd0) ? 6'd1 : 6'(2 * k + 2);
      len_mask = (32'd1 << (k + 5'd1)) - 32'd1;
      len_wide = (32'd1 << (k + 5'd1)) + ((win2 >> (6'd32 - lneed)) & len_mask);
      len      = (k == 5'd0) ? LEN_W'(3) : len_wide[LEN_W-1:0];
      total    = 7'(need) + 7'(lneed);
      cnt_ext  = 7'(cnt_ff);
      end_pos  = 18'(wp_ff) + 18'(len);

      // Copy start, reduced into the history range.
      src_diff   = 17'(wp_ff) - off;
      src_masked = src_diff[15:0] & (history_mode ? SRC_MASK_64K : SRC_MASK_8K);
      src_mod    = 17'(src_masked);
      for (int i = 0; i < 8; i++) begin
         if (src_mod >= 17'(HISTORY_SIZE)) begin
            src_mod = src_mod - 17'(HISTORY_SIZE);
         end
      end
      src_start = src_mod[AW-1:0];
   end

   // Source that follows the running copy and the one that follows a new copy start.
   always_comb begin
      src_next         = 17'(src_ff) + 17'd1;
      src_follow       = (src_next >= 17'(HISTORY_SIZE)) ? '0 : src_next[AW-1:0];
      src_start_next   = 17'(src_start) + 17'd1;
      src_start_follow = (src_start_next >= 17'(HISTORY_SIZE)) ? '0
                                                               : src_start_next[AW-1:0];
   end

   // Next-state logic for one accepted word.
   logic       data_path;
   logic       is_fail;
   logic [3:0] fail_code;

   always_comb begin
      wp_in     = wp_ff;
      start_in  = start_ff;
      hwm_in    = hwm_ff;
      buf_in    = buf_ff;
      cnt_in    = cnt_ff;
      src_in    = src_ff;
      rem_in    = rem_ff;
      act_in    = act_ff;
      comp_in   = comp_ff;
      end_in    = end_ff;
      hold_in   = hold_ff;
      desc      = '0;
      desc.status = ST_ACCEPTED;
      rd_addr   = src_ff;
      wr_addr   = wp_ff[AW-1:0];
      data_path = 1'b0;
      is_fail   = 1'b0;
      fail_code = ST_BAD_OFFSET;

      if (accept) begin
         if (item.operation == OP_TICK) begin
            desc.status = ST_WAIT;
            if (act_ff && comp_ff) begin
               if (rem_ff != '0) begin
                  // Next byte of a copy in progress.
                  desc.status  = ST_DECODED;
                  desc.use_mem = 1'b1;
                  desc.wen     = (wp_ff < PW'(HISTORY_SIZE));
                  wp_in        = wp_ff + PW'(1);
                  src_in       = src_follow;
                  rem_in       = rem_ff - LEN_W'(1);
               end else if (cnt_ff < CW'(8)) begin
                  if (end_ff) begin
                     desc.status = ST_DONE;
                     desc.eop    = 1'b1;
                     act_in      = 1'b0;
                     comp_in     = 1'b0;
                     end_in      = 1'b0;
                     buf_in      = '0;
                     cnt_in      = '0;
                  end
               end else if (wp_ff >= PW'(HISTORY_SIZE)) begin
                  is_fail   = 1'b1;
                  fail_code = ST_HIST_FULL;
               end else if (is_lit) begin
                  if (7'(lit_need) > cnt_ext) begin
                     if (end_ff) begin
                        is_fail   = 1'b1;
                        fail_code = ST_BAD_OFFSET;
                     end
                  end else begin
                     desc.status = ST_DECODED;
                     desc.lit    = lit_byte;
                     desc.wen    = 1'b1;
                     buf_in      = buf_ff << lit_need;
                     cnt_in      = cnt_ff - CW'(lit_need);
                     wp_in       = wp_ff + PW'(1);
                  end
               end else if (7'(need) > cnt_ext) begin
                  if (end_ff) begin
                     is_fail   = 1'b1;
                     fail_code = ST_BAD_OFFSET;
                  end
               end else if (k >= k_limit) begin
                  is_fail   = 1'b1;
                  fail_code = ST_BAD_LENGTH;
               end else if (total > cnt_ext) begin
                  if (end_ff) begin
                     is_fail   = 1'b1;
                     fail_code = ST_BAD_LENGTH;
                  end
               end else if (end_pos > 18'(HISTORY_SIZE)) begin
                  is_fail   = 1'b1;
                  fail_code = ST_OVERFLOW;
               end else begin
                  // Start a copy and emit its first byte now.
                  desc.status  = ST_DECODED;
                  desc.use_mem = 1'b1;
                  desc.wen     = 1'b1;
                  rd_addr      = src_start;
                  buf_in       = buf_ff << total;
                  cnt_in       = cnt_ff - CW'(total);
                  wp_in        = wp_ff + PW'(1);
                  src_in       = src_start_follow;
                  rem_in       = len - LEN_W'(1);
               end
            end
         end else if (item.first_of_packet) begin
            // A new packet abandons whatever was open.
            rem_in  = '0;
            buf_in  = '0;
            cnt_in  = '0;
            hold_in = 1'b0;
            if (item.flag_at_front || item.flag_flushed) begin
               wp_in = '0;
            end
            if (item.flag_flushed) begin
               hwm_in = '0;
            end
            start_in  = (item.flag_at_front || item.flag_flushed) ? '0 : wp_ff;
            act_in    = 1'b1;
            comp_in   = item.flag_compressed;
            end_in    = 1'b0;
            data_path = 1'b1;
         end else if (!act_ff || end_ff) begin
            // Stray byte, dropped.
            if (hold_ff && item.last_of_packet) begin
               hold_in = 1'b0;
            end
         end else begin
            data_path = 1'b1;
         end

         // Byte of an open packet: pass it on or take it into the bit buffer.
         if (data_path) begin
            if (!comp_in) begin
               desc.status = ST_PASS;
               desc.lit    = item.data_byte;
               desc.eop    = item.last_of_packet;
               if (item.last_of_packet) begin
                  act_in  = 1'b0;
                  comp_in = 1'b0;
                  end_in  = 1'b0;
               end
            end else if (7'(cnt_in) + 7'd8 > 7'(BB)) begin
               desc.status = ST_FULL;
            end else begin
               buf_in = buf_in | ({item.data_byte, {(BB-8){1'b0}}} >> cnt_in);
               cnt_in = cnt_in + CW'(8);
               if (item.last_of_packet) begin
                  end_in = 1'b1;
               end
            end
         end

         // Error: roll back to the packet start and close the packet.
         if (is_fail) begin
            desc        = '0;
            desc.status = fail_code;
            desc.eop    = 1'b1;
            wp_in       = start_ff;
            buf_in      = '0;
            cnt_in      = '0;
            rem_in      = '0;
            hold_in     = !end_ff;
            act_in      = 1'b0;
            comp_in     = 1'b0;
            end_in      = 1'b0;
         end
      end

      // Entries at or above the high-water mark read as zero since the last flush.
      if (desc.wen && (wp_ff >= hwm_ff)) begin
         hwm_in = wp_ff + PW'(1);
      end
      desc.rd_valid = (PW'(rd_addr) < hwm_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         start_ff <= '0;
         hwm_ff   <= '0;
         buf_ff   <= '0;
         cnt_ff   <= '0;
         src_ff   <= '0;
         rem_ff   <= '0;
         act_ff   <= 1'b0;
         comp_ff  <= 1'b0;
         end_ff   <= 1'b0;
         hold_ff  <= 1'b0;
      end else begin
         wp_ff    <= wp_in;
         start_ff <= start_in;
         hwm_ff   <= hwm_in;
         buf_ff   <= buf_in;
         cnt_ff   <= cnt_in;
         src_ff   <= src_in;
         rem_ff   <= rem_in;
         act_ff   <= act_in;
         comp_ff  <= comp_in;
         end_ff   <= end_in;
         hold_ff  <= hold_in;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(BB))
      else $error("bit count beyond buffer size");
   a_copy_open : assert property (@(posedge clock) disable iff (reset)
      (rem_ff != '0) |-> (act_ff && comp_ff))
      else $error("copy pending without an open compressed packet");
   a_hwm_cover : assert property (@(posedge clock) disable iff (reset)
      wp_ff <= hwm_ff)
      else $error("write position above high-water mark");
`endif

endmodule

`default_nettype wire

/* rtl/core/mhd_history.sv */
`default_nettype none

module mhd_history import mhd_pkg::*; #(
   parameter int HISTORY_SIZE = HISTORY_SIZE_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         s0_valid,
   input  wire mhd_desc_type                 s0_desc,
   input  wire logic [$clog2(HISTORY_SIZE)-1:0] s0_rd_addr,
   input  wire logic [$clog2(HISTORY_SIZE)-1:0] s0_wr_addr,
   output logic                              s1_valid,
   output mhd_result_type                    s1_result
);

   localparam int AW = $clog2(HISTORY_SIZE);

   logic [7:0]    mem [HISTORY_SIZE];
   logic [7:0]    q_ff;
   logic          s1_valid_ff;
   mhd_desc_type  s1_desc_ff;
   logic [AW-1:0] s1_rd_addr_ff;
   logic [AW-1:0] s1_wr_addr_ff;
   logic          fwd_valid_ff;
   logic [AW-1:0] fwd_addr_ff;
   logic [7:0]    fwd_data_ff;
   logic [7:0]    s1_byte;

   // Read stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid;
      end
      s1_desc_ff    <= s0_desc;
      s1_rd_addr_ff <= s0_rd_addr;
      s1_wr_addr_ff <= s0_wr_addr;
   end

   // The write of the previous cycle is not yet in the read data.
   always_comb begin
      if (!s1_desc_ff.use_mem) begin
         s1_byte = s1_desc_ff.lit;
      end else if (!s1_desc_ff.rd_valid) begin
         s1_byte = 8'd0;
      end else if (fwd_valid_ff && (fwd_addr_ff == s1_rd_addr_ff)) begin
         s1_byte = fwd_data_ff;
      end else begin
         s1_byte = q_ff;
      end
   end

   // History memory: read issued by the decoder, write from this stage.
   always_ff @(posedge clock) begin
      if (s0_valid) begin
         q_ff <= mem[s0_rd_addr];
      end
      if (s1_valid_ff && s1_desc_ff.wen) begin
         mem[s1_wr_addr_ff] <= s1_byte;
      end
   end

   // Last write, kept for the read that follows it.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (s1_valid_ff && s1_desc_ff.wen) begin
         fwd_valid_ff <= 1'b1;
      end
      if (s1_valid_ff && s1_desc_ff.wen) begin
         fwd_addr_ff <= s1_wr_addr_ff;
         fwd_data_ff <= s1_byte;
      end
   end

   assign s1_valid                = s1_valid_ff;
   assign s1_result.out_byte      = s1_byte;
   assign s1_result.status        = s1_desc_ff.status;
   assign s1_result.end_of_packet = s1_desc_ff.eop;

endmodule

`default_nettype wire

/* rtl/core/mhd_out_queue.sv */
`default_nettype none

module mhd_out_queue import mhd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire mhd_result_type push_word,
   input  wire logic           pop,
   output logic                not_empty,
   output mhd_result_type      head_word,
   output logic [$clog2(OUTQ_DEPTH+1)-1:0] count
);

   localparam int PTRW = $clog2(OUTQ_DEPTH);
   localparam int CNTW = $clog2(OUTQ_DEPTH + 1);

   mhd_result_type  entry_ff [OUTQ_DEPTH];
   logic [PTRW-1:0] wr_ptr_ff;
   logic [PTRW-1:0] rd_ptr_ff;
   logic [CNTW-1:0] cnt_ff;

   // Pointer advance with wrap at the queue depth.
   function automatic logic [PTRW-1:0] ptr_step(input logic [PTRW-1:0] p);
      ptr_step = (p == PTRW'(OUTQ_DEPTH - 1)) ? '0 : p + PTRW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_step(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_step(rd_ptr_ff);
         end
         cnt_ff <= cnt_ff + CNTW'(push) - CNTW'(pop);
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign not_empty = (cnt_ff != '0);
   assign head_word = entry_ff[rd_ptr_ff];
   assign count     = cnt_ff;

endmodule

`default_nettype wire

/* rtl/core/mppc_history_decompressor_core.sv */
`default_nettype none

// MPPC history decompressor, 8K or 64K history codes. Each input word is either
// a packet byte push or an output tick, and each gives exactly one result word.
// The block accepts one word per clock while the result queue has room; a tick
// that continues a history copy yields one decompressed byte, so a copy of
// length N takes N ticks. The decoder decodes each word and issues the history
// read address; the read stage then does the registered history memory read and
// the write-back of the produced byte. A three-word result queue keeps input
// flowing while results wait. A flush needs no clearing pass: entries not
// rewritten since the last flush read as zero through a high-water mark.
// Register history_mode at byte address 0 (bit 0, reset 1) selects 64K codes.
module mppc_history_decompressor_core import mhd_pkg::*; #(
   parameter int HISTORY_SIZE    = HISTORY_SIZE_DEF,
   parameter int BIT_BUFFER_BITS = BIT_BUFFER_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mhd_req_if.sink          req_chan,
   mhd_rsp_if.source        rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int AW   = $clog2(HISTORY_SIZE);
   localparam int CNTW = $clog2(OUTQ_DEPTH + 1);

   logic           mode_ff;
   logic           accept;
   mhd_item_type   item;
   mhd_desc_type   desc;
   logic [AW-1:0]  rd_addr;
   logic [AW-1:0]  wr_addr;
   logic           s1_valid;
   mhd_result_type s1_result;
   logic           q_not_empty;
   mhd_result_type q_head;
   logic [CNTW-1:0] q_count;

   // Control register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == REG_HISTORY_MODE)) begin
         mode_ff <= csr_pwdata[0];
      end
   end
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_HISTORY_MODE) ? {31'd0, mode_ff} : 32'd0;

   // Take a word only when the queue can hold it and the one in flight.
   assign req_chan.ready = ((CNTW+1)'(q_count) + (CNTW+1)'(s1_valid))
                           < (CNTW+1)'(OUTQ_DEPTH);
   assign accept = req_chan.valid && req_chan.ready;

   assign item.operation       = req_chan.operation;
   assign item.data_byte       = req_chan.data_byte;
   assign item.first_of_packet = req_chan.first_of_packet;
   assign item.last_of_packet  = req_chan.last_of_packet;
   assign item.flag_compressed = req_chan.flag_compressed;
   assign item.flag_at_front   = req_chan.flag_at_front;
   assign item.flag_flushed    = req_chan.flag_flushed;

   mhd_decoder #(
      .HISTORY_SIZE    (HISTORY_SIZE),
      .BIT_BUFFER_BITS (BIT_BUFFER_BITS)
   ) u_decoder (
      .clock        (clock),
      .reset        (reset),
      .history_mode (mode_ff),
      .accept       (accept),
      .item         (item),
      .desc         (desc),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr)
   );

   mhd_history #(
      .HISTORY_SIZE (HISTORY_SIZE)
   ) u_history (
      .clock      (clock),
      .reset      (reset),
      .s0_valid   (accept),
      .s0_desc    (desc),
      .s0_rd_addr (rd_addr),
      .s0_wr_addr (wr_addr),
      .s1_valid   (s1_valid),
      .s1_result  (s1_result)
   );

   mhd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid),
      .push_word (s1_result),
      .pop       (rsp_chan.valid && rsp_chan.ready),
      .not_empty (q_not_empty),
      .head_word (q_head),
      .count     (q_count)
   );

   assign rsp_chan.valid         = q_not_empty;
   assign rsp_chan.out_byte      = q_head.out_byte;
   assign rsp_chan.status        = q_head.status;
   assign rsp_chan.end_of_packet = q_head.end_of_packet;

endmodule

`default_nettype wire
